// File: rtl/dtc_pkg.sv
// dtc_pkg: widths and fixed constants of the day-number to tick-count unit
// shared by the channel interfaces, the rounding helper and the top level
// no dependencies
`timescale 1ns / 1ps

package dtc_pkg;

    // payload widths
    localparam int DAY_W  = 20;
    localparam int FRAC_W = 17;
    localparam int TICK_W = 31;

    // supported day range, relative to 1970-01-01
    localparam int VALID_LOW    = -354285;
    localparam int VALID_HIGH   = 376200;
    localparam int DAYS_TO_1970 = 719162;

    // internal widths
    localparam int DN_W     = 21;   // day number from 0001-01-01
    localparam int A_W      = 23;   // scaled day number, 4*dn + 3 + bias
    localparam int RECIP_W  = 15;
    localparam int CENT_W   = 5;
    localparam int REM_W    = 18;
    localparam int PROD_W   = 39;
    localparam int YEAR_W   = 12;
    localparam int HI_W     = PROD_W - 32;
    localparam int CDIV_W   = 13;
    localparam int C_W      = 6;
    localparam int FDY_W    = 23;
    localparam int DOY_W    = 9;

    localparam int FRAC_BITS = 16;

    // year search constants
    localparam logic [A_W-1:0]     CENT_BIAS   = 23'd1224;
    localparam logic [REM_W-1:0]   ERA_DAYS    = 18'd146097;
    localparam logic [RECIP_W-1:0] CENT_RECIP  = 15'd29398;  // floor(2^32 / 146097)
    localparam logic [21:0]        YEAR_MUL    = 22'd2939745;
    localparam logic [31:0]        MARCH_LIMIT = 32'd3598247880; // 306 * 11758980
    localparam logic [6:0]         YEARS_PER_CENT = 7'd100;

    // first day of year
    localparam logic [CDIV_W-1:0]  CDIV_MUL    = 13'd5243;   // k/100 == k*5243 >> 19
    localparam int                 CDIV_SHIFT  = 19;
    localparam logic [10:0]        DAYS_PER_4Y = 11'(365 * 4 + 1);

    // leap test
    localparam logic [31:0] LEAP_MUL   = 32'd1073750999;
    localparam logic [31:0] LEAP_MASK  = 32'd3221352463;
    localparam logic [31:0] LEAP_BOUND = 32'd126976;

    localparam logic [TICK_W-1:0] TICK_MAX = 31'h7FFF_FFFF;

endpackage

// File: rtl/dtc_ifs.sv
// dtc_date_if and dtc_tick_if: valid/ready channels of the day-number unit
// depends on dtc_pkg for the payload widths
`timescale 1ns / 1ps

interface dtc_date_if import dtc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DAY_W-1:0] day_number;
    logic [FRAC_W-1:0]       day_fraction;

    modport source (output valid, output day_number, output day_fraction, input ready);
    modport sink   (input valid, input day_number, input day_fraction, output ready);
endinterface

interface dtc_tick_if import dtc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_count;
    logic              valid_res;

    modport source (output valid, output tick_count, output valid_res, input ready);
    modport sink   (input valid, input tick_count, input valid_res, output ready);
endinterface

// File: rtl/dtc_round.sv
// dtc_round: drops the 16 fraction bits of a Q16 product, round half to even
// depends on dtc_pkg
`timescale 1ns / 1ps

module dtc_round import dtc_pkg::*; #(
    parameter int P_W = 28
) (
    input  logic [P_W-1:0]         p,
    output logic [P_W-FRAC_BITS:0] q
);

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic [FRAC_BITS-1:0]     lo;
    logic [P_W-FRAC_BITS-1:0] hi;
    logic                     up;

    always_comb
    begin
        lo = p[FRAC_BITS-1:0];
        hi = p[P_W-1:FRAC_BITS];
        up = (lo > HALF) || ((lo == HALF) && hi[0]);
        q  = {1'b0, hi} + (P_W-FRAC_BITS+1)'(up);
    end

endmodule

// File: rtl/day_number_to_tick_count_unit.sv
// day_number_to_tick_count_unit: top level, nine-stage date to tick pipeline
// depends on dtc_pkg, dtc_date_if, dtc_tick_if and dtc_round
//
// Converts a signed day count since 1970-01-01 plus a Q16 day fraction into
// year*TICKS_PER_YEAR + day_of_year*tpd + round_half_even(fraction*tpd), tpd
// being the leap or common ticks per day of the year found. Day counts outside
// [-354285, 376200) come out with valid_res low and tick_count zero; sums
// above 2^31-1 saturate. One transaction is accepted every cycle while the
// output is not stalled; a result passes through the nine register stages
// (scale, century estimate, century fix, year product, year, leap product,
// first day, day products, sum), the first of which loads at the edge that
// accepts its transaction. Back pressure holds every stage that has no free
// slot ahead of it and lets bubbles fill.
`timescale 1ns / 1ps

module day_number_to_tick_count_unit import dtc_pkg::*; #(
    parameter int TICKS_PER_YEAR       = 534360,
    parameter int TICKS_PER_DAY_COMMON = 1464,
    parameter int TICKS_PER_DAY_LEAP   = 1460
) (
    input  logic        clk,
    input  logic        rst_n,
    dtc_date_if.sink    date_ch,
    dtc_tick_if.source  tick_ch
);

    localparam int NUM_STAGES = 9;
    localparam int TPD_MAX = (TICKS_PER_DAY_COMMON > TICKS_PER_DAY_LEAP) ?
                             TICKS_PER_DAY_COMMON : TICKS_PER_DAY_LEAP;
    localparam int TPD_W  = $clog2(TPD_MAX + 1);
    localparam int TPY_W  = $clog2(TICKS_PER_YEAR + 1);
    localparam int P_W    = FRAC_W + TPD_W;
    localparam int Q_W    = P_W - FRAC_BITS + 1;
    localparam int YT_W   = YEAR_W + TPY_W;
    localparam int DT_W   = DOY_W + TPD_W;
    localparam int MAX_A  = (YT_W > DT_W) ? YT_W : DT_W;
    localparam int MAX_B  = (MAX_A > Q_W) ? MAX_A : Q_W;
    localparam int MAX_C  = (MAX_B > TICK_W) ? MAX_B : TICK_W;
    localparam int SUM_W  = MAX_C + 2;

    localparam logic [TPD_W-1:0] TPD_COMMON = TPD_W'(TICKS_PER_DAY_COMMON);
    localparam logic [TPD_W-1:0] TPD_LEAP   = TPD_W'(TICKS_PER_DAY_LEAP);
    localparam logic [TPY_W-1:0] TPY        = TPY_W'(TICKS_PER_YEAR);

    // stage handshake
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || tick_ch.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= date_ch.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign date_ch.ready = adv[0];
    assign tick_ch.valid = v_reg[NUM_STAGES-1];

    // stage 1: range check, shift to day number from year one, scale
    logic signed [31:0]  dn_sum;
    logic                ok1_next,  ok1_reg;
    logic [DN_W-1:0]     dn1_next,  dn1_reg;
    logic [A_W-1:0]      a1_next,   a1_reg;
    logic [FRAC_W-1:0]   frac1_reg;

    always_comb
    begin
        ok1_next = (int'(date_ch.day_number) >= VALID_LOW) &&
                   (int'(date_ch.day_number) < VALID_HIGH);
        dn_sum   = 32'(int'(date_ch.day_number) + DAYS_TO_1970);
        dn1_next = dn_sum[DN_W-1:0];
        a1_next  = {dn1_next, 2'b11} + CENT_BIAS;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ok1_reg   <= ok1_next;
            dn1_reg   <= dn1_next;
            a1_reg    <= a1_next;
            frac1_reg <= date_ch.day_fraction;
        end
    end

    // stage 2: century estimate by reciprocal, both fraction products
    logic [A_W+RECIP_W-1:0] est_prod;
    logic [CENT_W-1:0]      est2_next, est2_reg;
    logic [P_W-1:0]         pc2_next,  pc2_reg;
    logic [P_W-1:0]         pl2_next,  pl2_reg;
    logic                   ok2_reg;
    logic [DN_W-1:0]        dn2_reg;
    logic [A_W-1:0]         a2_reg;

    always_comb
    begin
        est_prod  = (A_W+RECIP_W)'(a1_reg) * (A_W+RECIP_W)'(CENT_RECIP);
        est2_next = est_prod[32 +: CENT_W];
        pc2_next  = P_W'(frac1_reg) * P_W'(TPD_COMMON);
        pl2_next  = P_W'(frac1_reg) * P_W'(TPD_LEAP);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            est2_reg <= est2_next;
            pc2_reg  <= pc2_next;
            pl2_reg  <= pl2_next;
            ok2_reg  <= ok1_reg;
            dn2_reg  <= dn1_reg;
            a2_reg   <= a1_reg;
        end
    end

    // stage 3: century fix-up, round the fraction products
    logic [A_W-1:0]    rem_raw;
    logic [CENT_W-1:0] cent3_next, cent3_reg;
    logic [REM_W-1:0]  rem3_next,  rem3_reg;
    logic [Q_W-1:0]    qc3_next,   qc3_reg;
    logic [Q_W-1:0]    ql3_next,   ql3_reg;
    logic              ok3_reg;
    logic [DN_W-1:0]   dn3_reg;

    always_comb
    begin
        // the estimate is low by at most one
        rem_raw = a2_reg - A_W'(A_W'(est2_reg) * A_W'(ERA_DAYS));
        if (rem_raw >= A_W'(ERA_DAYS))
        begin
            cent3_next = est2_reg + CENT_W'(1);
            rem3_next  = REM_W'(rem_raw - A_W'(ERA_DAYS));
        end
        else
        begin
            cent3_next = est2_reg;
            rem3_next  = REM_W'(rem_raw);
        end
    end

    dtc_round #(.P_W(P_W)) u_round_common (.p(pc2_reg), .q(qc3_next));
    dtc_round #(.P_W(P_W)) u_round_leap   (.p(pl2_reg), .q(ql3_next));

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            cent3_reg <= cent3_next;
            rem3_reg  <= rem3_next;
            qc3_reg   <= qc3_next;
            ql3_reg   <= ql3_next;
            ok3_reg   <= ok2_reg;
            dn3_reg   <= dn2_reg;
        end
    end

    // stage 4: year-in-century product
    logic [PROD_W-1:0] prod4_next, prod4_reg;
    logic [CENT_W-1:0] cent4_reg;
    logic [Q_W-1:0]    qc4_reg, ql4_reg;
    logic              ok4_reg;
    logic [DN_W-1:0]   dn4_reg;

    assign prod4_next = PROD_W'(rem3_reg | REM_W'(3)) * PROD_W'(YEAR_MUL);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            prod4_reg <= prod4_next;
            cent4_reg <= cent3_reg;
            qc4_reg   <= qc3_reg;
            ql4_reg   <= ql3_reg;
            ok4_reg   <= ok3_reg;
            dn4_reg   <= dn3_reg;
        end
    end

    // stage 5: year; january and february belong to the next year
    logic [YEAR_W-1:0] yr5_next, yr5_reg;
    logic              march;
    logic [Q_W-1:0]    qc5_reg, ql5_reg;
    logic              ok5_reg;
    logic [DN_W-1:0]   dn5_reg;

    always_comb
    begin
        march    = (prod4_reg[31:0] >= MARCH_LIMIT);
        yr5_next = YEAR_W'(YEAR_W'(cent4_reg) * YEAR_W'(YEARS_PER_CENT))
                 + YEAR_W'(prod4_reg[PROD_W-1:32]) + YEAR_W'(march);
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            yr5_reg <= yr5_next;
            qc5_reg <= qc4_reg;
            ql5_reg <= ql4_reg;
            ok5_reg <= ok4_reg;
            dn5_reg <= dn4_reg;
        end
    end

    // stage 6: previous year, its century, leap test product
    logic [YEAR_W-1:0]        k6_next, k6_reg;
    logic [YEAR_W+CDIV_W-1:0] c_prod;
    logic [C_W-1:0]           c6_next, c6_reg;
    logic [31:0]              lm6_next, lm6_reg;
    logic [YEAR_W-1:0]        yr6_reg;
    logic [Q_W-1:0]           qc6_reg, ql6_reg;
    logic                     ok6_reg;
    logic [DN_W-1:0]          dn6_reg;

    always_comb
    begin
        k6_next  = yr5_reg - YEAR_W'(1);
        c_prod   = (YEAR_W+CDIV_W)'(k6_next) * (YEAR_W+CDIV_W)'(CDIV_MUL);
        c6_next  = c_prod[CDIV_SHIFT +: C_W];
        lm6_next = 32'(32'(yr5_reg) * LEAP_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            k6_reg  <= k6_next;
            c6_reg  <= c6_next;
            lm6_reg <= lm6_next;
            yr6_reg <= yr5_reg;
            qc6_reg <= qc5_reg;
            ql6_reg <= ql5_reg;
            ok6_reg <= ok5_reg;
            dn6_reg <= dn5_reg;
        end
    end

    // stage 7: first day of the year, leap flag
    logic [FDY_W-1:0]  fdy7_next, fdy7_reg;
    logic [FDY_W-1:0]  k_days;
    logic              leap7_next, leap7_reg;
    logic [YEAR_W-1:0] yr7_reg;
    logic [Q_W-1:0]    qc7_reg, ql7_reg;
    logic              ok7_reg;
    logic [DN_W-1:0]   dn7_reg;

    always_comb
    begin
        k_days     = FDY_W'(k6_reg) * FDY_W'(DAYS_PER_4Y);
        fdy7_next  = (k_days >> 2) - FDY_W'(c6_reg) + FDY_W'(c6_reg >> 2);
        leap7_next = ((lm6_reg & LEAP_MASK) <= LEAP_BOUND);
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            fdy7_reg  <= fdy7_next;
            leap7_reg <= leap7_next;
            yr7_reg   <= yr6_reg;
            qc7_reg   <= qc6_reg;
            ql7_reg   <= ql6_reg;
            ok7_reg   <= ok6_reg;
            dn7_reg   <= dn6_reg;
        end
    end

    // stage 8: year ticks, day ticks, fraction ticks
    logic [FDY_W-1:0] doy_full;
    logic [DOY_W-1:0] doy;
    logic [TPD_W-1:0] tpd;
    logic [YT_W-1:0]  yt8_next, yt8_reg;
    logic [DT_W-1:0]  dt8_next, dt8_reg;
    logic [Q_W-1:0]   q8_next,  q8_reg;
    logic             ok8_reg;

    always_comb
    begin
        doy_full = FDY_W'(dn7_reg) - fdy7_reg;
        doy      = doy_full[DOY_W-1:0];
        tpd      = leap7_reg ? TPD_LEAP : TPD_COMMON;
        yt8_next = YT_W'(yr7_reg) * YT_W'(TPY);
        dt8_next = DT_W'(doy) * DT_W'(tpd);
        q8_next  = leap7_reg ? ql7_reg : qc7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            yt8_reg <= yt8_next;
            dt8_reg <= dt8_next;
            q8_reg  <= q8_next;
            ok8_reg <= ok7_reg;
        end
    end

    // stage 9: sum, saturate, zero out-of-range days
    logic [SUM_W-1:0]  total;
    logic [TICK_W-1:0] tick9_next, tick9_reg;
    logic              vres9_reg;

    always_comb
    begin
        total = SUM_W'(yt8_reg) + SUM_W'(dt8_reg) + SUM_W'(q8_reg);
        if (!ok8_reg)
        begin
            tick9_next = '0;
        end
        else if (total > SUM_W'(TICK_MAX))
        begin
            tick9_next = TICK_MAX;
        end
        else
        begin
            tick9_next = total[TICK_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            tick9_reg <= tick9_next;
            vres9_reg <= ok8_reg;
        end
    end

    assign tick_ch.tick_count = tick9_reg;
    assign tick_ch.valid_res  = vres9_reg;

endmodule

// File: rtl/dtc_checker.sv
// dtc_checker: port-level assertions for day_number_to_tick_count_unit
// depends on dtc_pkg; bound to the top level at the end of this file
`timescale 1ns / 1ps

module dtc_checker import dtc_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              date_valid,
    input logic              date_ready,
    input logic              tick_valid,
    input logic              tick_ready,
    input logic [TICK_W-1:0] tick_count,
    input logic              valid_res
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !tick_ready |=> tick_valid && $stable(tick_count) && $stable(valid_res))
    else $error("stalled result changed or dropped");

    // out-of-range days give a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !valid_res |-> tick_count == '0)
    else $error("invalid result with nonzero tick count");

    // a free output slot lets the whole pipe move
    assert property (@(posedge clk) disable iff (!rst_n)
        (!tick_valid || tick_ready) |-> date_ready)
    else $error("input stalled while output is free");

    // nothing comes out of an empty pipe straight after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !tick_valid)
    else $error("result valid right after reset");

endmodule

bind day_number_to_tick_count_unit dtc_checker u_dtc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .date_valid (date_ch.valid),
    .date_ready (date_ch.ready),
    .tick_valid (tick_ch.valid),
    .tick_ready (tick_ch.ready),
    .tick_count (tick_ch.tick_count),
    .valid_res  (tick_ch.valid_res)
);
